// File: rtl/core/cdq_pkg.sv
// Shared types and constants for the coordinate deque.
package cdq_pkg;

    localparam int DEPTH_DEF       = 256;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FUNC_W          = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_PUSH_FRONT = 3'd1,
        FN_POP_BACK   = 3'd2,
        FN_POP_FRONT  = 3'd3,
        FN_SEARCH     = 3'd4,
        FN_CLEAR      = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // What every cell of the chain does on the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHR,
        CELL_ROL
    } t_cell_op;

endpackage

// File: rtl/core/cdq_cell.sv
// One storage cell of the deque chain, holding a single coordinate pair.
module cdq_cell #(
    parameter int COORD_WIDTH = cdq_pkg::COORD_WIDTH_DEF,
    parameter int CNT_W       = 9,
    parameter int INDEX       = 0
) (
    input  logic                     i_clk,
    input  cdq_pkg::t_cell_op        i_op,
    input  logic [CNT_W-1:0]         i_count,
    input  logic [2*COORD_WIDTH-1:0] i_push,
    input  logic [2*COORD_WIDTH-1:0] i_left,
    input  logic [2*COORD_WIDTH-1:0] i_right,
    output logic [2*COORD_WIDTH-1:0] o_ent
);

    logic [2*COORD_WIDTH-1:0] r_ent;
    logic [2*COORD_WIDTH-1:0] n_ent;

    always_comb begin
        n_ent = r_ent;
        case (i_op)
            cdq_pkg::CELL_HOLD: n_ent = r_ent;
            cdq_pkg::CELL_LOAD: begin
                // A push at the back lands in the first free cell.
                if (i_count == CNT_W'(INDEX)) begin
                    n_ent = i_push;
                end
            end
            cdq_pkg::CELL_SHR:  n_ent = i_left;
            cdq_pkg::CELL_ROL:  n_ent = i_right;
            default:            n_ent = r_ent;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent = r_ent;

endmodule

// File: rtl/core/cdq_ctrl.sv
// Operation sequencer, head comparator and result register of the deque.
module cdq_ctrl #(
    parameter int DEPTH       = cdq_pkg::DEPTH_DEF,
    parameter int COORD_WIDTH = cdq_pkg::COORD_WIDTH_DEF,
    parameter int CNT_W       = $clog2(DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [cdq_pkg::FUNC_W-1:0] i_func,
    input  logic [2*COORD_WIDTH-1:0]   i_pair,
    input  logic [2*COORD_WIDTH-1:0]   i_head,
    output cdq_pkg::t_cell_op          o_cell_op,
    output logic [CNT_W-1:0]           o_count,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_out_ok,
    output logic [2*COORD_WIDTH-1:0]   o_out_pair,
    output logic [CNT_W-1:0]           o_out_count
);

    localparam int STEP_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PAIR_W = 2 * COORD_WIDTH;

    cdq_pkg::t_state          r_state, n_state;
    cdq_pkg::t_func           r_op, n_op;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [STEP_W-1:0]        r_step, n_step;
    logic [PAIR_W-1:0]        r_key, n_key;
    logic                     r_res_ok, n_res_ok;
    logic [PAIR_W-1:0]        r_res_pair, n_res_pair;
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_ok, n_out_ok;
    logic [PAIR_W-1:0]        r_out_pair, n_out_pair;
    logic [CNT_W-1:0]         r_out_count, n_out_count;
    cdq_pkg::t_cell_op        cell_op;
    cdq_pkg::t_func           in_func;
    logic                     not_full;
    logic                     not_empty;
    logic                     last_step;
    logic [CNT_W-1:0]         step_ext;

    assign in_func   = cdq_pkg::t_func'(i_func);
    assign not_full  = (r_count < CNT_W'(DEPTH));
    assign not_empty = (r_count != '0);
    assign last_step = (r_step == STEP_W'(DEPTH - 1));
    assign step_ext  = CNT_W'(r_step);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_count     = r_count;
        n_step      = r_step;
        n_key       = r_key;
        n_res_ok    = r_res_ok;
        n_res_pair  = r_res_pair;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_pair  = r_out_pair;
        n_out_count = r_out_count;
        cell_op     = cdq_pkg::CELL_HOLD;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            cdq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_op       = in_func;
                    n_key      = i_pair;
                    n_res_ok   = 1'b0;
                    n_res_pair = '0;
                    n_step     = '0;
                    n_state    = cdq_pkg::ST_DONE;
                    case (in_func)
                        cdq_pkg::FN_PUSH_BACK: begin
                            if (not_full) begin
                                cell_op  = cdq_pkg::CELL_LOAD;
                                n_count  = r_count + 1'b1;
                                n_res_ok = 1'b1;
                            end
                        end
                        cdq_pkg::FN_PUSH_FRONT: begin
                            if (not_full) begin
                                cell_op  = cdq_pkg::CELL_SHR;
                                n_count  = r_count + 1'b1;
                                n_res_ok = 1'b1;
                            end
                        end
                        cdq_pkg::FN_POP_FRONT: begin
                            if (not_empty) begin
                                cell_op    = cdq_pkg::CELL_ROL;
                                n_res_pair = i_head;
                                n_count    = r_count - 1'b1;
                                n_res_ok   = 1'b1;
                            end
                        end
                        cdq_pkg::FN_POP_BACK, cdq_pkg::FN_SEARCH: begin
                            if (not_empty) begin
                                n_state = cdq_pkg::ST_SCAN;
                            end
                        end
                        cdq_pkg::FN_CLEAR: begin
                            n_count  = '0;
                            n_res_ok = 1'b1;
                        end
                        default: begin
                            n_res_ok = 1'b0;
                        end
                    endcase
                end
            end
            cdq_pkg::ST_SCAN: begin
                // The ring turns once completely; cell 0 shows entry r_step each cycle.
                cell_op = cdq_pkg::CELL_ROL;
                n_step  = r_step + 1'b1;
                if (r_op == cdq_pkg::FN_SEARCH) begin
                    if ((step_ext < r_count) && (i_head == r_key)) begin
                        n_res_ok = 1'b1;
                    end
                end else begin
                    if (step_ext == (r_count - 1'b1)) begin
                        n_res_ok   = 1'b1;
                        n_res_pair = i_head;
                    end
                end
                if (last_step) begin
                    n_step  = '0;
                    n_state = cdq_pkg::ST_DONE;
                    if (r_op == cdq_pkg::FN_POP_BACK) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            cdq_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_pair  = r_res_pair;
                    n_out_count = r_count;
                    n_state     = cdq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_op        <= n_op;
        r_key       <= n_key;
        r_res_ok    <= n_res_ok;
        r_res_pair  <= n_res_pair;
        r_out_ok    <= n_out_ok;
        r_out_pair  <= n_out_pair;
        r_out_count <= n_out_count;
    end

    assign o_in_ready  = (r_state == cdq_pkg::ST_IDLE);
    assign o_cell_op   = cell_op;
    assign o_count     = r_count;
    assign o_out_valid = r_out_valid;
    assign o_out_ok    = r_out_ok;
    assign o_out_pair  = r_out_pair;
    assign o_out_count = r_out_count;

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdq_pkg::ST_SCAN) |-> (r_count != '0))
        else $error("scan running on an empty deque");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdq_pkg::ST_IDLE && i_in_valid && in_func == cdq_pkg::FN_PUSH_FRONT
         && !not_full) |=> (r_count == CNT_W'(DEPTH)))
        else $error("refused push changed the count");

    a_pop_back_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdq_pkg::ST_SCAN && last_step && r_op == cdq_pkg::FN_POP_BACK)
        |=> (r_count == $past(r_count) - 1'b1) && r_res_ok)
        else $error("pop at the back did not remove exactly one entry");

    a_scan_rotates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdq_pkg::ST_SCAN) |-> (cell_op == cdq_pkg::CELL_ROL) && !o_in_ready)
        else $error("chain not rotating during a scan");

    a_done_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdq_pkg::ST_DONE && !r_out_valid)
        |=> r_out_valid && (r_out_count == $past(r_count)))
        else $error("finished result not moved to the output register");

endmodule

// File: rtl/core/coordinate_deque_with_search.sv
// Push back, push front, pop front, clear and unknown codes go from the idle state to the
// done state and then to the output register. Pop back and search on a non-empty deque
// pass through the scan state first, where the chain rotates once past cell 0. A new
// transaction is taken only in the idle state, so the next one waits until the result has
// moved to the output register; a stalled output holds the result and the input.
// Reset clears the count, the sequencer and the output valid; cell contents are not cleared.
// Top level of the coordinate deque: cell chain, sequencer and stream ports.
module coordinate_deque_with_search #(
    parameter int  DEPTH       = cdq_pkg::DEPTH_DEF,
    parameter int  COORD_WIDTH = cdq_pkg::COORD_WIDTH_DEF,
    localparam int CNT_W       = $clog2(DEPTH + 1),
    localparam int PAIR_W      = 2 * COORD_WIDTH,
    localparam int IN_DW       = ((PAIR_W + 7) / 8) * 8,
    localparam int OUT_DW      = ((PAIR_W + CNT_W + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IN_DW-1:0]           s_axis_tdata,  // pos_x, pos_y, zero pad
    input  logic [cdq_pkg::FUNC_W-1:0] s_axis_tuser,  // func
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [OUT_DW-1:0]          m_axis_tdata,  // out_x, out_y, count, zero pad
    output logic [0:0]                 m_axis_tuser   // ok
);

    logic [PAIR_W-1:0]  push_pair;
    logic [PAIR_W-1:0]  w_ent [DEPTH];
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   out_count;
    logic [PAIR_W-1:0]  out_pair;
    logic               out_ok;
    cdq_pkg::t_cell_op  cell_op;

    assign push_pair = s_axis_tdata[PAIR_W-1:0];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [PAIR_W-1:0] left_ent;
        logic [PAIR_W-1:0] right_ent;

        if (g == 0) begin : g_first
            assign left_ent = push_pair;
        end else begin : g_inner
            assign left_ent = w_ent[g-1];
        end

        // The last cell wraps to the first so a full rotation restores the order.
        if (g == DEPTH - 1) begin : g_last
            assign right_ent = w_ent[0];
        end else begin : g_body
            assign right_ent = w_ent[g+1];
        end

        cdq_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .CNT_W       (CNT_W),
            .INDEX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_count (count),
            .i_push  (push_pair),
            .i_left  (left_ent),
            .i_right (right_ent),
            .o_ent   (w_ent[g])
        );
    end

    cdq_ctrl #(
        .DEPTH       (DEPTH),
        .COORD_WIDTH (COORD_WIDTH),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_func      (s_axis_tuser),
        .i_pair      (push_pair),
        .i_head      (w_ent[0]),
        .o_cell_op   (cell_op),
        .o_count     (count),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_ok    (out_ok),
        .o_out_pair  (out_pair),
        .o_out_count (out_count)
    );

    assign m_axis_tdata = OUT_DW'({out_count, out_pair});
    assign m_axis_tuser = out_ok;

endmodule

// File: tb/coordinate_deque_with_search_checker.sv
`timescale 1ns / 100ps
// Checker for the coordinate deque: follows both streams, predicts every result and compares.
module coordinate_deque_with_search_checker #(
    parameter int DEPTH  = cdq_pkg::DEPTH_DEF,
    parameter int CW     = cdq_pkg::COORD_WIDTH_DEF,
    parameter int CNT_W  = $clog2(DEPTH + 1),
    parameter int IN_DW  = ((2 * CW + 7) / 8) * 8,
    parameter int OUT_DW = ((2 * CW + CNT_W + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [IN_DW-1:0]           i_in_data,   // pos_x, pos_y, zero pad
    input  logic [cdq_pkg::FUNC_W-1:0] i_in_user,   // func
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [OUT_DW-1:0]          i_out_data,  // out_x, out_y, count, zero pad
    input  logic [0:0]                 i_out_user,  // ok
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);

    typedef struct packed {
        logic             ok;
        logic [CW-1:0]    x;
        logic [CW-1:0]    y;
        logic [CNT_W-1:0] cnt;
    } t_deque_result;

    // Shadow copy of the deque contents.
    logic [CW-1:0] store_x [DEPTH];
    logic [CW-1:0] store_y [DEPTH];
    int            front;
    int            held;

    t_deque_result awaited_results [$];
    int            fail_count;
    int            checked;

    assign o_fail_count = fail_count;
    assign o_pending    = awaited_results.size();
    assign o_checked    = checked;

    function automatic t_deque_result deque_step(input logic [cdq_pkg::FUNC_W-1:0] fn,
                                                 input logic [CW-1:0] px,
                                                 input logic [CW-1:0] py);
        t_deque_result r;
        int            slot;
        r = '0;
        case (fn)
            cdq_pkg::FN_PUSH_BACK: begin
                if (held < DEPTH) begin
                    slot          = (front + held) % DEPTH;
                    store_x[slot] = px;
                    store_y[slot] = py;
                    held++;
                    r.ok = 1'b1;
                end
            end
            cdq_pkg::FN_PUSH_FRONT: begin
                if (held < DEPTH) begin
                    front          = (front + DEPTH - 1) % DEPTH;
                    store_x[front] = px;
                    store_y[front] = py;
                    held++;
                    r.ok = 1'b1;
                end
            end
            cdq_pkg::FN_POP_BACK: begin
                if (held > 0) begin
                    slot = (front + held - 1) % DEPTH;
                    r.x  = store_x[slot];
                    r.y  = store_y[slot];
                    held--;
                    r.ok = 1'b1;
                end
            end
            cdq_pkg::FN_POP_FRONT: begin
                if (held > 0) begin
                    r.x   = store_x[front];
                    r.y   = store_y[front];
                    front = (front + 1) % DEPTH;
                    held--;
                    r.ok  = 1'b1;
                end
            end
            cdq_pkg::FN_SEARCH: begin
                for (int k = 0; k < held; k++) begin
                    slot = (front + k) % DEPTH;
                    if (store_x[slot] == px && store_y[slot] == py) r.ok = 1'b1;
                end
            end
            cdq_pkg::FN_CLEAR: begin
                front = 0;
                held  = 0;
                r.ok  = 1'b1;
            end
            default: begin
                // Reserved codes leave the state alone and report not ok with a zero pair and the count.
            end
        endcase
        r.cnt = CNT_W'(held);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (fail_count < 10)
            $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_deque_result want;
        t_deque_result got;
        if (!i_rst_n) begin
            front      = 0;
            held       = 0;
            fail_count = 0;
            checked    = 0;
            awaited_results.delete();
        end else begin
            // Compare before queuing, so a result can never match its own transaction.
            if (i_out_valid && i_out_ready) begin
                got.ok  = i_out_user[0];
                got.x   = i_out_data[CW-1:0];
                got.y   = i_out_data[2*CW-1:CW];
                got.cnt = i_out_data[2*CW+CNT_W-1:2*CW];
                if (awaited_results.size() == 0) begin
                    note_mismatch("unexpected result", 64'(0), 64'(got));
                end else begin
                    want = awaited_results.pop_front();
                    if (got.ok !== want.ok)
                        note_mismatch("ok", 64'(want.ok), 64'(got.ok));
                    if (got.x !== want.x)
                        note_mismatch("out_x", 64'(want.x), 64'(got.x));
                    if (got.y !== want.y)
                        note_mismatch("out_y", 64'(want.y), 64'(got.y));
                    if (got.cnt !== want.cnt)
                        note_mismatch("count", 64'(want.cnt), 64'(got.cnt));
                end
                checked++;
            end
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(deque_step(i_in_user, i_in_data[CW-1:0],
                                                     i_in_data[2*CW-1:CW]));
        end
    end

endmodule

// File: tb/coordinate_deque_with_search_tb.sv
`timescale 1ns / 100ps
// Testbench top for the coordinate deque: drives operations, applies back-pressure, reports.
module coordinate_deque_with_search_tb;

    localparam int DEPTH        = cdq_pkg::DEPTH_DEF;
    localparam int CW           = cdq_pkg::COORD_WIDTH_DEF;
    localparam int FUNC_W       = cdq_pkg::FUNC_W;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int IN_DW        = ((2 * CW + 7) / 8) * 8;
    localparam int OUT_DW       = ((2 * CW + CNT_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RECENT_N     = 32;

    localparam logic [FUNC_W-1:0] FN_RSVD_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_7 = 3'd7;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata  = '0;   // pos_x, pos_y, zero pad
    logic [FUNC_W-1:0] s_axis_tuser  = '0;   // func
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;         // out_x, out_y, count, zero pad
    logic [0:0]        m_axis_tuser;         // ok

    int fail_count;
    int pending;
    int checked;

    int send_idle  = 33;
    int recv_idle  = 62;
    int cycles     = 0;
    int held       = 0;
    int full_hits  = 0;
    int empty_pops = 0;
    int n_push     = 0;
    int n_pop      = 0;
    int n_search   = 0;
    int n_clear    = 0;
    int n_rsvd     = 0;

    logic [CW-1:0] recent_x [RECENT_N];
    logic [CW-1:0] recent_y [RECENT_N];
    int            recent_fill = 0;

    coordinate_deque_with_search #(
        .DEPTH       (DEPTH),
        .COORD_WIDTH (CW)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    coordinate_deque_with_search_checker #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results still outstanding.",
                     cycles, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Mostly full-range values, with a small pool and the extremes mixed in for duplicates.
    function automatic logic [CW-1:0] pick_coord();
        logic [CW-1:0] v;
        case ($urandom_range(0, 3))
            0, 1: v = CW'($urandom);
            2:    v = CW'($urandom_range(0, 4) - 2);
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = {1'b1, {(CW-1){1'b0}}};
                    1:       v = {1'b0, {(CW-1){1'b1}}};
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [CW-1:0] px,
                             input logic [CW-1:0] py);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= IN_DW'({py, px});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // Rough occupancy so the random part can steer toward full and empty.
        case (fn)
            cdq_pkg::FN_PUSH_BACK, cdq_pkg::FN_PUSH_FRONT: begin
                n_push++;
                if (held == DEPTH - 1) full_hits++;
                if (held < DEPTH) held++;
                recent_x[recent_fill % RECENT_N] = px;
                recent_y[recent_fill % RECENT_N] = py;
                recent_fill++;
            end
            cdq_pkg::FN_POP_BACK, cdq_pkg::FN_POP_FRONT: begin
                n_pop++;
                if (held > 0) held--;
                else empty_pops++;
            end
            cdq_pkg::FN_SEARCH: n_search++;
            cdq_pkg::FN_CLEAR: begin
                n_clear++;
                held = 0;
            end
            default: n_rsvd++;
        endcase
    endtask

    task automatic send_search();
        int pick;
        if (recent_fill > 0 && $urandom_range(0, 1) == 1) begin
            pick = $urandom_range(0, ((recent_fill < RECENT_N) ? recent_fill : RECENT_N) - 1);
            send_item(cdq_pkg::FN_SEARCH, recent_x[pick], recent_y[pick]);
        end else begin
            send_item(cdq_pkg::FN_SEARCH, pick_coord(), pick_coord());
        end
    endtask

    initial begin
        logic filling;
        int   r;
        filling = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty deque: both pops and a search come back with nothing.
        send_item(cdq_pkg::FN_POP_FRONT, CW'($urandom), CW'($urandom));
        send_item(cdq_pkg::FN_POP_BACK, CW'($urandom), CW'($urandom));
        send_item(cdq_pkg::FN_SEARCH, '0, '0);
        // Extreme coordinates from both ends.
        send_item(cdq_pkg::FN_PUSH_BACK, 16'h7FFF, 16'h8000);
        send_item(cdq_pkg::FN_PUSH_FRONT, 16'h8000, 16'h7FFF);
        send_item(cdq_pkg::FN_PUSH_BACK, 16'h0000, 16'h0000);
        send_item(cdq_pkg::FN_PUSH_FRONT, 16'hFFFF, 16'hFFFF);
        send_item(cdq_pkg::FN_SEARCH, 16'hFFFF, 16'hFFFF);
        send_item(cdq_pkg::FN_SEARCH, 16'h0000, 16'h0000);
        send_item(cdq_pkg::FN_SEARCH, 16'h7FFF, 16'h8000);
        // Only x matches here, so the search must miss.
        send_item(cdq_pkg::FN_SEARCH, 16'h7FFF, 16'h7FFF);
        send_item(FN_RSVD_6, 16'hA5A5, 16'h5A5A);
        send_item(FN_RSVD_7, 16'hFFFF, 16'hFFFF);
        send_item(cdq_pkg::FN_POP_BACK, '0, '0);
        send_item(cdq_pkg::FN_POP_FRONT, '1, '1);
        send_item(cdq_pkg::FN_CLEAR, CW'($urandom), CW'($urandom));
        send_item(cdq_pkg::FN_POP_BACK, '0, '0);
        send_item(cdq_pkg::FN_SEARCH, 16'h8000, 16'h7FFF);
        // Front push after a clear wraps the front index to the top of the ring.
        send_item(cdq_pkg::FN_PUSH_FRONT, 16'h1234, 16'hEDCB);
        send_item(cdq_pkg::FN_PUSH_BACK, 16'h8001, 16'h7FFE);
        send_item(cdq_pkg::FN_POP_BACK, '0, '0);
        send_item(cdq_pkg::FN_POP_BACK, '0, '0);
        send_item(cdq_pkg::FN_CLEAR, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle = 62;
                recv_idle = 33;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            // Linger a little at full and empty so refused pushes and empty pops occur.
            if (filling && held == DEPTH && $urandom_range(0, 7) == 0) filling = 1'b0;
            else if (!filling && held == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
            else if ($urandom_range(0, 199) == 0) filling = !filling;
            r = $urandom_range(0, 99);
            if (filling) begin
                if (r < 40)
                    send_item(cdq_pkg::FN_PUSH_BACK, pick_coord(), pick_coord());
                else if (r < 80)
                    send_item(cdq_pkg::FN_PUSH_FRONT, pick_coord(), pick_coord());
                else if (r < 84)
                    send_item(cdq_pkg::FN_POP_BACK, CW'($urandom), CW'($urandom));
                else if (r < 88)
                    send_item(cdq_pkg::FN_POP_FRONT, CW'($urandom), CW'($urandom));
                else if (r < 99)
                    send_search();
                else
                    send_item($urandom_range(0, 1) ? FN_RSVD_6 : FN_RSVD_7,
                              CW'($urandom), CW'($urandom));
            end else begin
                if (r < 5)
                    send_item(cdq_pkg::FN_PUSH_BACK, pick_coord(), pick_coord());
                else if (r < 10)
                    send_item(cdq_pkg::FN_PUSH_FRONT, pick_coord(), pick_coord());
                else if (r < 45)
                    send_item(cdq_pkg::FN_POP_BACK, CW'($urandom), CW'($urandom));
                else if (r < 80)
                    send_item(cdq_pkg::FN_POP_FRONT, CW'($urandom), CW'($urandom));
                else if (r < 97)
                    send_search();
                else if (r < 99)
                    send_item(cdq_pkg::FN_CLEAR, CW'($urandom), CW'($urandom));
                else
                    send_item($urandom_range(0, 1) ? FN_RSVD_6 : FN_RSVD_7,
                              CW'($urandom), CW'($urandom));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);

        $display("Checked %0d results: %0d pushes, %0d pops (%0d on empty), %0d searches,",
                 checked, n_push, n_pop, empty_pops, n_search);
        $display("%0d clears, %0d reserved codes; the deque filled up %0d times.",
                 n_clear, n_rsvd, full_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
